@@ sv/i2d128_pkg.sv @@
// Shared constants and helper functions for the int128 to decimal128 DPD converter.
package i2d128_pkg;

  localparam int unsigned NDIG     = 39;
  localparam int unsigned PREC     = 34;
  localparam int unsigned DD_BITS  = 8;
  localparam int unsigned DD_STG   = 128 / DD_BITS;
  localparam int unsigned BCD_W    = 4 * NDIG;
  localparam int unsigned COEF_W   = 4 * PREC;
  localparam logic [13:0] BIAS     = 14'd6176;

  typedef logic [BCD_W-1:0]  bcd_t;
  typedef logic [COEF_W-1:0] coef_t;

  // one shift-and-add-3 step of double dabble
  function automatic bcd_t dabble_step(bcd_t b, logic bit_in);
    bcd_t r;
    r = b;
    for (int k = 0; k < NDIG; k++) begin
      if (r[4*k +: 4] >= 4'd5) begin
        r[4*k +: 4] = r[4*k +: 4] + 4'd3;
      end
    end
    return {r[BCD_W-2:0], bit_in};
  endfunction

  // three BCD digits to one declet
  function automatic logic [9:0] dpd_encode(logic [3:0] d2, logic [3:0] d1, logic [3:0] d0);
    logic p, q, r, s, t, u, v, w, x, y;
    logic [2:0] sel;
    sel = {d2[3], d1[3], d0[3]};
    r = d2[0]; u = d1[0]; y = d0[0];
    v = 1'b1; w = 1'b1; x = 1'b1;
    p = d2[2]; q = d2[1]; s = d1[2]; t = d1[1];
    case (sel)
      3'd0: begin v = 1'b0; w = d0[2]; x = d0[1]; end
      3'd1: begin w = 1'b0; x = 1'b0; end
      3'd2: begin s = d0[2]; t = d0[1]; w = 1'b0; x = 1'b1; end
      3'd3: begin s = 1'b1; t = 1'b0; end
      3'd4: begin p = d0[2]; q = d0[1]; w = 1'b1; x = 1'b0; end
      3'd5: begin p = d1[2]; q = d1[1]; s = 1'b0; t = 1'b1; end
      3'd6: begin p = d0[2]; q = d0[1]; s = 1'b0; t = 1'b0; end
      default: begin p = 1'b0; q = 1'b0; s = 1'b1; t = 1'b1; end
    endcase
    return {p, q, r, s, t, u, v, w, x, y};
  endfunction

endpackage

@@ sv/int128_to_decimal128_dpd.sv @@
// Top level: pipelined 128-bit integer to decimal128 DPD converter.
// One word is accepted per cycle unless stalled; stages: sign/magnitude, 16 double
// dabble stages of 8 bits each, digit alignment, rounding increment, DPD packing.
// The pipeline advances as a whole; it stalls only while the output word is held.
module int128_to_decimal128_dpd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_high_i,
  input  logic [63:0] value_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] dec_high_o,
  output logic [63:0] dec_low_o
);
  import i2d128_pkg::*;

  logic en;
  logic mode_q;

  logic         v0_q, neg0_q;
  logic [127:0] mag0_q;

  logic         vd_q   [DD_STG+1];
  logic         negd_q [DD_STG+1];
  bcd_t         bcd_q  [DD_STG+1];
  logic [127:0] bin_q  [DD_STG+1];

  logic        v1_q, neg1_q, stk1_q;
  coef_t       coef1_q;
  logic [3:0]  rd1_q;
  logic [2:0]  drop1_q;

  logic        v2_q, neg2_q;
  coef_t       coef2_q;
  logic [2:0]  drop2_q;

  logic        vo_q;
  logic [63:0] dh_q, dl_q;

  assign en          = !(vo_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // stage 0: sign and magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg0_q <= !mode_q && value_high_i[63];
      mag0_q <= (!mode_q && value_high_i[63]) ? (~{value_high_i, value_low_i} + 128'd1)
                                               : {value_high_i, value_low_i};
    end
  end

  assign vd_q[0]   = v0_q;
  assign negd_q[0] = neg0_q;
  assign bcd_q[0]  = '0;
  assign bin_q[0]  = mag0_q;

  // double dabble pipeline
  for (genvar g = 1; g <= DD_STG; g++) begin : g_dd
    bcd_t         b_d, b_q;
    logic [127:0] n_d, n_q;
    logic         v_q, neg_q;

    always_comb begin
      b_d = bcd_q[g-1];
      n_d = bin_q[g-1];
      for (int k = 0; k < DD_BITS; k++) begin
        b_d = dabble_step(b_d, n_d[127]);
        n_d = {n_d[126:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= vd_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        b_q   <= b_d;
        n_q   <= n_d;
        neg_q <= negd_q[g-1];
      end
    end

    assign vd_q[g]   = v_q;
    assign negd_q[g] = neg_q;
    assign bcd_q[g]  = b_q;
    assign bin_q[g]  = n_q;
  end

  // alignment: digits dropped, round digit, sticky
  bcd_t       dig;
  logic [2:0] drop_d;
  coef_t      coef_d;
  logic [3:0] rd_d;
  logic       stk_d;

  assign dig = bcd_q[DD_STG];

  always_comb begin
    if (dig[4*38 +: 4] != 4'd0)      drop_d = 3'd5;
    else if (dig[4*37 +: 4] != 4'd0) drop_d = 3'd4;
    else if (dig[4*36 +: 4] != 4'd0) drop_d = 3'd3;
    else if (dig[4*35 +: 4] != 4'd0) drop_d = 3'd2;
    else if (dig[4*34 +: 4] != 4'd0) drop_d = 3'd1;
    else                             drop_d = 3'd0;
    case (drop_d)
      3'd1: begin
        coef_d = dig[4 +: COEF_W];  rd_d = dig[3:0];   stk_d = 1'b0;
      end
      3'd2: begin
        coef_d = dig[8 +: COEF_W];  rd_d = dig[7:4];   stk_d = |dig[3:0];
      end
      3'd3: begin
        coef_d = dig[12 +: COEF_W]; rd_d = dig[11:8];  stk_d = |dig[7:0];
      end
      3'd4: begin
        coef_d = dig[16 +: COEF_W]; rd_d = dig[15:12]; stk_d = |dig[11:0];
      end
      3'd5: begin
        coef_d = dig[20 +: COEF_W]; rd_d = dig[19:16]; stk_d = |dig[15:0];
      end
      default: begin
        coef_d = dig[0 +: COEF_W];  rd_d = 4'd0;       stk_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= vd_q[DD_STG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg1_q  <= negd_q[DD_STG];
      coef1_q <= coef_d;
      rd1_q   <= rd_d;
      stk1_q  <= stk_d;
      drop1_q <= drop_d;
    end
  end

  // round half to even
  coef_t      rc_d;
  logic [2:0] rdrop_d;
  logic       cy;

  always_comb begin
    rc_d = coef1_q;
    cy = (rd1_q > 4'd5) || (rd1_q == 4'd5 && (stk1_q || coef1_q[0]));
    for (int k = 0; k < PREC; k++) begin
      if (cy) begin
        if (rc_d[4*k +: 4] == 4'd9) begin
          rc_d[4*k +: 4] = 4'd0;
        end else begin
          rc_d[4*k +: 4] = rc_d[4*k +: 4] + 4'd1;
          cy = 1'b0;
        end
      end
    end
    rdrop_d = drop1_q;
    if (cy) begin
      rc_d = '0;
      rc_d[4*(PREC-1)] = 1'b1;
      rdrop_d = drop1_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg2_q  <= neg1_q;
      coef2_q <= rc_d;
      drop2_q <= rdrop_d;
    end
  end

  // DPD packing
  logic [127:0] enc_d;
  logic [13:0]  bexp;
  logic [3:0]   msd;
  logic [4:0]   g5;

  always_comb begin
    enc_d = '0;
    for (int k = 0; k < 11; k++) begin
      enc_d[10*k +: 10] = dpd_encode(coef2_q[12*k+8 +: 4], coef2_q[12*k+4 +: 4],
                                     coef2_q[12*k +: 4]);
    end
    bexp = BIAS + {11'd0, drop2_q};
    msd  = coef2_q[4*(PREC-1) +: 4];
    if (msd < 4'd8) g5 = {bexp[13:12], msd[2:0]};
    else            g5 = {2'b11, bexp[13:12], msd[0]};
    enc_d[121:110] = bexp[11:0];
    enc_d[126:122] = g5;
    enc_d[127]     = neg2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dh_q <= enc_d[127:64];
      dl_q <= enc_d[63:0];
    end
  end

  assign out_valid_o = vo_q;
  assign dec_high_o  = dh_q;
  assign dec_low_o   = dl_q;

`ifndef SYNTHESIS
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  a_exp_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dec_high_o[62:61] == 2'b01 ||
                     (dec_high_o[62:61] == 2'b11 && dec_high_o[60:59] == 2'b01)))
    else $error("exponent out of range");

  a_pipe_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v2_q) |=> out_valid_o)
    else $error("word lost at output stage");
`endif

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the int128 to decimal128 DPD converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY = 20;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned NUM_RANDOM = 384;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] value_high_i = '0;
  logic [63:0] value_low_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] dec_high_o;
  logic [63:0] dec_low_o;

  int128_to_decimal128_dpd dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } dec128_t;

  typedef struct {
    logic [127:0] value;
    logic         known;
    dec128_t      enc;
  } stim_row_t;

  dec128_t     pending_enc[$];
  logic        mode_unsigned = 1'b0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          stimulus_done = 1'b0;

  function automatic logic [9:0] declet(logic [3:0] d2, logic [3:0] d1, logic [3:0] d0);
    logic [9:0] r;
    r = {d2[2], d2[1], d2[0], d1[2], d1[1], d1[0], 1'b1, 1'b1, 1'b1, d0[0]};
    case ({d2[3], d1[3], d0[3]})
      3'b000: begin r[3] = 1'b0; r[2] = d0[2]; r[1] = d0[1]; end
      3'b001: begin r[2] = 1'b0; r[1] = 1'b0; end
      3'b010: begin r[6] = d0[2]; r[5] = d0[1]; r[2] = 1'b0; end
      3'b011: begin r[6] = 1'b1; r[5] = 1'b0; end
      3'b100: begin r[9] = d0[2]; r[8] = d0[1]; r[1] = 1'b0; end
      3'b101: begin r[9] = d1[2]; r[8] = d1[1]; r[6] = 1'b0; r[5] = 1'b1; end
      3'b110: begin r[9] = d0[2]; r[8] = d0[1]; r[6] = 1'b0; r[5] = 1'b0; end
      default: begin r[9] = 1'b0; r[8] = 1'b0; r[6] = 1'b1; r[5] = 1'b1; end
    endcase
    return r;
  endfunction

  function automatic dec128_t to_decimal128(logic [127:0] v, logic unsigned_in);
    logic [3:0]   dig[39];
    logic [3:0]   coef[34];
    logic [127:0] mag;
    logic [127:0] enc;
    logic         neg;
    logic         sticky;
    logic         up;
    int           ndig;
    int           drop;
    int           carry;
    logic [13:0]  bexp;
    logic [3:0]   msd;
    logic [4:0]   g5;
    neg = !unsigned_in && v[127];
    mag = neg ? -v : v;
    ndig = 0;
    for (int i = 0; i < 39; i++) begin
      dig[i] = 4'(mag % 128'd10);
      mag = mag / 128'd10;
      if (dig[i] != 0) ndig = i + 1;
    end
    drop = 0;
    if (ndig > 34) begin
      drop = ndig - 34;
      sticky = 1'b0;
      for (int i = 0; i < drop - 1; i++) if (dig[i] != 0) sticky = 1'b1;
      for (int i = 0; i < 34; i++) coef[i] = dig[drop + i];
      up = dig[drop-1] > 5 || (dig[drop-1] == 5 && (sticky || coef[0][0]));
      carry = up ? 1 : 0;
      for (int i = 0; i < 34; i++) begin
        if (carry != 0) begin
          if (coef[i] == 4'd9) coef[i] = 4'd0;
          else begin
            coef[i] = coef[i] + 4'd1;
            carry = 0;
          end
        end
      end
      if (carry != 0) begin
        coef[33] = 4'd1;
        drop++;
      end
    end else begin
      for (int i = 0; i < 34; i++) coef[i] = dig[i];
    end
    enc = '0;
    for (int i = 0; i < 11; i++) enc[10*i +: 10] = declet(coef[3*i+2], coef[3*i+1], coef[3*i]);
    bexp = 14'd6176 + 14'(drop);
    msd = coef[33];
    if (msd < 4'd8) g5 = {bexp[13:12], msd[2:0]};
    else g5 = {2'b11, bexp[13:12], msd[0]};
    enc[121:110] = bexp[11:0];
    enc[126:122] = g5;
    enc[127] = neg && ndig != 0;
    return enc;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_enc.size() == 0) begin
        report_mismatch("unexpected word", dec_high_o, dec_low_o);
      end else begin
        if (dec_high_o !== pending_enc[0].hi) report_mismatch("dec_high", dec_high_o, pending_enc[0].hi);
        if (dec_low_o !== pending_enc[0].lo) report_mismatch("dec_low", dec_low_o, pending_enc[0].lo);
        void'(pending_enc.pop_front());
      end
    end
  end

  // receiver stalls in its own pattern, with quiet stretches
  always @(posedge clk_i) begin
    int unsigned ph;
    ph = $urandom_range(0, 99);
    if (!stimulus_done && ph < 30) out_stall_i <= 1'b1;
    else if (ph < 40 && !stimulus_done) out_stall_i <= 1'($urandom_range(0, 1));
    else out_stall_i <= 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send_word(logic [127:0] v);
    value_high_i <= v[127:64];
    value_low_i <= v[63:0];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_enc.push_back(to_decimal128(v, mode_unsigned));
  endtask

  task automatic drop_valid_gap();
    int unsigned gap;
    gap = $urandom_range(1, 6);
    in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    while (pending_enc.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
    cfg_data_i <= m;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_unsigned = m;
  endtask

  function automatic logic [127:0] random_value();
    logic [127:0] v;
    int unsigned kind;
    v = {$urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(0, 7);
    case (kind)
      0: v = v >> $urandom_range(0, 127);
      1: v = -(v >> $urandom_range(1, 127));
      2: v = 128'd9999999999999999999999999999999999 * 128'(10 ** $urandom_range(0, 4))
             + 128'($urandom_range(0, 20)) - 128'd10;
      3: v = 128'd10000000000000000000000000000000000 * 128'($urandom_range(1, 9999))
             + 128'($urandom_range(0, 10000));
      default: ;
    endcase
    return v;
  endfunction

  stim_row_t directed[$];

  initial begin
    logic [127:0] pow34;
    int unsigned  burst_left;
    dec128_t      want;
    pow34 = 128'd10000000000000000000000000000000000;
    directed = '{
      '{128'd0, 1'b1, 128'h2208_0000_0000_0000_0000_0000_0000_0000},
      '{128'd1, 1'b1, 128'h2208_0000_0000_0000_0000_0000_0000_0001},
      '{128'd9, 1'b0, '0},
      '{128'd999, 1'b0, '0},
      '{{1'b0, {127{1'b1}}}, 1'b0, '0},
      '{{1'b1, 127'd0}, 1'b0, '0},
      '{{128{1'b1}}, 1'b1, 128'hA208_0000_0000_0000_0000_0000_0000_0001},
      '{pow34 - 1, 1'b0, '0},
      '{pow34, 1'b0, '0},
      '{pow34 * 10 - 5, 1'b0, '0},
      '{pow34 * 10 - 15, 1'b0, '0},
      '{pow34 * 10 + 5, 1'b0, '0},
      '{pow34 * 10 + 15, 1'b0, '0},
      '{pow34 * 10 + 16, 1'b0, '0},
      '{-(pow34 * 10 - 5), 1'b0, '0},
      '{128'h5555_5555_5555_5555_AAAA_AAAA_AAAA_AAAA, 1'b0, '0},
      '{128'hAAAA_AAAA_AAAA_AAAA_5555_5555_5555_5555, 1'b0, '0}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 4; p++) begin
      if (p == 1) write_mode(1'b1);
      if (p == 2) write_mode(1'b0);
      if (p == 3) write_mode(1'b1);
      foreach (directed[i]) begin
        if (directed[i].known && p == 0) begin
          want = to_decimal128(directed[i].value, 1'b0);
          if (want !== directed[i].enc)
            report_mismatch("table", directed[i].enc.hi, want.hi);
        end
        send_word(directed[i].value);
        if ($urandom_range(0, 3) == 0) drop_valid_gap();
      end
      burst_left = $urandom_range(1, 20);
      for (int n = 0; n < NUM_RANDOM / 4; n++) begin
        send_word(random_value());
        if (burst_left == 0) begin
          drop_valid_gap();
          burst_left = $urandom_range(1, 30);
        end else burst_left--;
      end
      in_valid_i <= 1'b0;
    end
    stimulus_done = 1'b1;
    while (pending_enc.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule

@@ sim.f @@
sv/i2d128_pkg.sv
sv/int128_to_decimal128_dpd.sv
test/tb_top.sv
